### sv/shadow_return_stack_unit_defines.svh
// ----------------------------------------------------------------------------
// shadow return stack assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SHADOW_RETURN_STACK_UNIT_DEFINES_SVH
`define SHADOW_RETURN_STACK_UNIT_DEFINES_SVH

// property must hold at every edge out of reset
`define SRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// shared types and constants of the shadow return stack
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int unsigned RET_ADDR_W = 64;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  // register index, byte address is 4 * index
  typedef enum logic [APB_AW-3:0] {
    REG_STACK_ENABLE = 1'b0
  } reg_idx_e;

  typedef enum logic {
    ACT_CALL   = 1'b0,
    ACT_RETURN = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOSTACK   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_e;

  // decision taken at acceptance, finished in the compare stage
  typedef struct packed {
    logic                  cmp;    // return that popped an entry, compare pending
    status_e               status; // final status when cmp is low
    logic [RET_ADDR_W-1:0] addr;   // presented return address
  } srs_issue_t;

endpackage

`default_nettype wire

### sv/srs_ram.sv
// ----------------------------------------------------------------------------
// srs_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// entry count, full/empty decisions and stack memory access at acceptance
// ----------------------------------------------------------------------------
`default_nettype none

module srs_front import srs_pkg::*; #(
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  enable_i,
  input  wire logic                  action_i,
  input  wire logic [RET_ADDR_W-1:0] addr_i,
  output srs_issue_t                 issue_o,
  output logic                       mem_we_o,
  output logic      [AW-1:0]         mem_waddr_o,
  output logic                       mem_re_o,
  output logic      [AW-1:0]         mem_raddr_o,
  output logic      [CNT_W-1:0]      count_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_q, count_d;
  logic             is_full, is_empty, do_push, do_pop;
  logic [CNT_W-1:0] top_idx;

  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);
  assign do_push  = enable_i && (action_e'(action_i) == ACT_CALL) && !is_full;
  assign do_pop   = enable_i && (action_e'(action_i) == ACT_RETURN) && !is_empty;
  assign top_idx  = count_q - 1'b1;

  always_comb begin
    issue_o.cmp  = do_pop;
    issue_o.addr = addr_i;
    if (!enable_i) begin
      issue_o.status = ST_NOSTACK;
    end else if (action_e'(action_i) == ACT_CALL) begin
      issue_o.status = is_full ? ST_OVERFLOW : ST_OK;
    end else begin
      issue_o.status = is_empty ? ST_UNDERFLOW : ST_OK;
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept_i && do_push) begin
      count_d = count_q + 1'b1;
    end else if (accept_i && do_pop) begin
      count_d = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // push writes slot count, pop reads slot count - 1
  assign mem_we_o    = accept_i && do_push;
  assign mem_waddr_o = count_q[AW-1:0];
  assign mem_re_o    = accept_i && do_pop;
  assign mem_raddr_o = top_idx[AW-1:0];
  assign count_o     = count_q;

endmodule

`default_nettype wire

### sv/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// compare stage against the read top entry and registered result slot
// ----------------------------------------------------------------------------
`default_nettype none

module srs_back import srs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  srs_issue_t                 issue_i,
  input  wire logic [RET_ADDR_W-1:0] rdata_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output status_e                    status_o,
  output logic                       kill_o
);

  logic       s1_valid_q, s1_valid_d;
  srs_issue_t s1_q;
  logic       out_valid_q, out_valid_d;
  status_e    status_q, status_d;
  logic       s1_adv;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    if (s1_q.cmp) begin
      status_d = (rdata_i == s1_q.addr) ? ST_OK : ST_MISMATCH;
    end else begin
      status_d = s1_q.status;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= issue_i;
    end
    if (s1_valid_q && s1_adv) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign kill_o      = (status_q != ST_OK);

endmodule

`default_nettype wire

### sv/shadow_return_stack_unit.sv
// ----------------------------------------------------------------------------
// shadow_return_stack_unit
// return-address shadow stack: calls push, returns pop and compare
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is a call (tuser 0, pushes tdata) or a
// return (tuser 1, pops the top entry and checks it against tdata). Every
// transfer yields one result transfer with a status and a kill flag. One
// transfer per cycle is sustained in both directions while the result stream
// is ready. The entry count and the stack memory are updated at acceptance,
// the memory's registered read port returns the top entry, and the compare
// lands in the result register. A push is written at its own edge, so a
// return right behind it reads the new top without forwarding. The stack
// memory needs no clearing pass; only entries below the count are ever read.
// stack_enable lives at byte address 0.
`default_nettype none
`include "shadow_return_stack_unit_defines.svh"

module shadow_return_stack_unit import srs_pkg::*; #(
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [RET_ADDR_W-1:0] s_axis_tdata,  // [63:0] addr
  input  wire logic                  s_axis_tuser,  // [0] action
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [7:0]            m_axis_tdata,  // [2:0] status, [3] kill, [7:4] zero
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // configuration register
  logic     enable_q;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_wr && (cfg_idx == REG_STACK_ENABLE)) begin
      enable_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_STACK_ENABLE: prdata[0] = enable_q;
      default:          prdata    = '0;
    endcase
  end

  // stream accept
  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // front: count and memory access
  srs_issue_t       issue;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CNT_W-1:0] count;

  srs_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .enable_i    (enable_q),
    .action_i    (s_axis_tuser),
    .addr_i      (s_axis_tdata),
    .issue_o     (issue),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .count_o     (count)
  );

  // stack memory
  logic [RET_ADDR_W-1:0] rdata;

  srs_ram #(
    .WIDTH (RET_ADDR_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // back: compare and result register
  status_e status;
  logic    kill;

  srs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .issue_i     (issue),
    .rdata_i     (rdata),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .kill_o      (kill)
  );

  assign m_axis_tdata = {4'b0000, kill, status};

  // checks
  `SRS_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH),
    "entry count above depth")
  `SRS_ASSERT_NEXT(a_count_hold, !accept, $stable(count),
    "entry count moved without a transfer")
  `SRS_ASSERT_NEXT(a_push_grows,
    accept && enable_q && !s_axis_tuser && (count != CNT_W'(DEPTH)),
    count == $past(count) + 1'b1, "accepted call did not push")
  `SRS_ASSERT_ALWAYS(a_kill_status, !m_axis_tvalid || (kill == (status != ST_OK)),
    "kill disagrees with status")

endmodule

`default_nettype wire
